@@ rtl/olist_pkg.sv @@
// olist_pkg: shared types and codes for the ordered value list
// item structs, opcode and status codes, controller/datapath command and status
// no dependencies
package olist_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DUMP   = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DELETE = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FOUND    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // source of the result value
  typedef enum logic [1:0] {
    VSEL_ECHO  = 2'd0,
    VSEL_ENTRY = 2'd1,
    VSEL_ZERO  = 2'd2
  } vsel_e;

  typedef struct packed {
    opcode_e            opcode;
    logic signed [31:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    status_e            status;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    walk_init;
    logic    shift_init;
    logic    rd_issue;
    logic    wr_append;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    vsel_e   vsel;
    status_e status;
    logic    last;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    count_zero;
    logic    full;
    logic    idx_lt_count;
    logic    rvalid;
    logic    match;
    logic    rlast;
  } dp_stat_t;

endpackage

@@ rtl/ordered_value_list.sv @@
// ordered_value_list: top level of the bounded ordered list of signed values
// joins the controller and the datapath
// depends on olist_pkg, olist_ctrl, olist_dp (and olist_ram below it)
//
// Usage
//   Input: drive in_item_i and raise start; the item is taken at a rising edge
//   with start high and busy low. Opcodes: append, dump, search, delete first
//   match. Results appear on result_o for one cycle each, marked by
//   result_valid_o; result_o.last marks the final result of an item. The
//   receiver cannot stall the block, so every strobe is a delivered result.
//   Sequence: busy holds from the accepting edge until the last result of the
//   item is on the ports, which happens in the first cycle with busy low, so
//   the next item can be taken while that result is still on the ports.
//     append, or any item on an empty list: ends after the dispatch state
//     search: walks up to the first match, or to the tail on a miss
//     dump: one result per entry, one per cycle
//     delete: walks to the first match, then moves each later entry one
//       place down to close the gap (no move when the tail matches); a miss walks the whole list
//   The walk and the gap closing go one entry per cycle through the single
//   read port of the entry ram; the worst case is a delete that hits any
//   entry but the tail of a full list.
//   Reset empties the list at once: the fill count, walk index, read tracking,
//   result strobe and control state are cleared, the entry ram is not swept.
module ordered_value_list #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  olist_pkg::in_item_t  in_item_i,
  output logic                 result_valid_o,
  output olist_pkg::out_item_t result_o
);

  import olist_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  olist_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  olist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_item_i      (in_item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // only dump entries may come without last
  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.status != ST_OK) |-> result_o.last)
    else $error("non-entry result without last");

  // never grow the list past its depth
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !stat.full)
    else $error("append into a full list");

  // no ram write while a shift read is missing
  a_shift_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_shift |-> (stat.rvalid && !cmd.wr_append))
    else $error("shift write without read data");

endmodule

@@ rtl/olist_ram.sv @@
// olist_ram: generic single write port, single read port ram
// registered read data, no reset on storage
// no dependencies
module olist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/olist_ctrl.sv @@
// olist_ctrl: sequencing state machine of the ordered value list
// drives datapath commands from datapath status
// depends on olist_pkg
module olist_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  olist_pkg::dp_stat_t   stat_i,
  output logic                  busy_o,
  output olist_pkg::ctrl_cmd_t  cmd_o
);

  import olist_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_DISP  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.vsel = VSEL_ECHO;
    cmd_o.status = ST_OK;
    cmd_o.last = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        case (stat_i.op)
          OP_APPEND: begin
            cmd_o.emit = 1'b1;
            if (stat_i.full) begin
              cmd_o.status = ST_FULL;
            end else begin
              cmd_o.wr_append = 1'b1;
              cmd_o.cnt_inc   = 1'b1;
            end
            state_d = S_IDLE;
          end
          OP_DUMP, OP_SEARCH: begin
            if (stat_i.count_zero) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_EMPTY;
              cmd_o.vsel   = (stat_i.op == OP_DUMP) ? VSEL_ZERO : VSEL_ECHO;
              state_d      = S_IDLE;
            end else begin
              cmd_o.walk_init = 1'b1;
              state_d         = S_WALK;
            end
          end
          default: begin
            if (stat_i.count_zero) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_NOTFOUND;
              state_d      = S_IDLE;
            end else begin
              cmd_o.walk_init = 1'b1;
              state_d         = S_WALK;
            end
          end
        endcase
      end
      S_WALK: begin
        if (stat_i.op == OP_DUMP) begin
          // one entry out per returned read
          cmd_o.rd_issue = stat_i.idx_lt_count;
          if (stat_i.rvalid) begin
            cmd_o.emit = 1'b1;
            cmd_o.vsel = VSEL_ENTRY;
            cmd_o.last = stat_i.rlast;
            if (stat_i.rlast) begin
              state_d = S_IDLE;
            end
          end
        end else begin
          // compare each returned entry, stop at first match or at the tail
          cmd_o.rd_issue = stat_i.idx_lt_count &&
                           !(stat_i.rvalid && (stat_i.match || stat_i.rlast));
          if (stat_i.rvalid && stat_i.match) begin
            if (stat_i.op == OP_SEARCH) begin
              cmd_o.emit   = 1'b1;
              cmd_o.status = ST_FOUND;
              state_d      = S_IDLE;
            end else begin
              cmd_o.shift_init = 1'b1;
              state_d          = S_SHIFT;
            end
          end else if (stat_i.rvalid && stat_i.rlast) begin
            cmd_o.emit   = 1'b1;
            cmd_o.status = ST_NOTFOUND;
            state_d      = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        // read entry i+1, write it back at i on the next cycle
        cmd_o.rd_issue = stat_i.idx_lt_count;
        cmd_o.wr_shift = stat_i.rvalid;
        if (!stat_i.idx_lt_count && !stat_i.rvalid) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.emit    = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/olist_dp.sv @@
// olist_dp: datapath of the ordered value list
// entry ram, fill count, walk index, read tracking and result register
// depends on olist_pkg and olist_ram
module olist_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  olist_pkg::in_item_t   in_item_i,
  input  olist_pkg::ctrl_cmd_t  cmd_i,
  output olist_pkg::dp_stat_t   stat_o,
  output logic                  result_valid_o,
  output olist_pkg::out_item_t  result_o
);

  import olist_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  opcode_e     op_q;
  logic [31:0] value_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q;
  logic          rvalid_q;
  logic [AW-1:0] ridx_q;
  logic          res_valid_q;
  out_item_t     res_q;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [31:0]   rdata;

  // latch the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_item_i.opcode;
      value_q <= in_item_i.operand_value;
    end
  end

  // fill count, walk index and read tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.walk_init) begin
        idx_q <= '0;
      end else if (cmd_i.shift_init) begin
        idx_q <= CW'(ridx_q) + CW'(1);
      end else if (cmd_i.rd_issue) begin
        idx_q <= idx_q + CW'(1);
      end
      rvalid_q <= cmd_i.rd_issue;
    end
  end

  // address of the data on the read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_issue) begin
      ridx_q <= idx_q[AW-1:0];
    end
  end

  // ram write: append at the tail or move an entry one place down
  assign we    = cmd_i.wr_append | cmd_i.wr_shift;
  assign waddr = cmd_i.wr_append ? count_q[AW-1:0] : (ridx_q - AW'(1));
  assign wdata = cmd_i.wr_append ? value_q : rdata;

  olist_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // status to the controller
  assign stat_o.op           = op_q;
  assign stat_o.count_zero   = (count_q == '0);
  assign stat_o.full         = (count_q == CW'(DEPTH));
  assign stat_o.idx_lt_count = (idx_q < count_q);
  assign stat_o.rvalid       = rvalid_q;
  assign stat_o.match        = (rdata == value_q);
  assign stat_o.rlast        = ((CW'(ridx_q) + CW'(1)) == count_q);

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      case (cmd_i.vsel)
        VSEL_ENTRY: res_q.item_value <= rdata;
        VSEL_ZERO:  res_q.item_value <= '0;
        default:    res_q.item_value <= value_q;
      endcase
      res_q.status <= cmd_i.status;
      res_q.last   <= cmd_i.last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
